FILE: src/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    localparam int MAX_CODE_BITS = 16;
    localparam int SYMBOL_COUNT  = 256;

    localparam int OP_W   = 2;
    localparam int SYM_W  = 8;
    localparam int CODE_W = 16;
    localparam int LEN_W  = 5;
    localparam int BYTE_W = 8;

    localparam int LEN_LIMIT = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
    localparam int ADDR_W    = $clog2(SYMBOL_COUNT);
    localparam int ENTRY_W   = CODE_W + LEN_W;
    localparam int PEND_W    = BYTE_W - 1;
    localparam int CNT_W     = 3;
    localparam int ACC_W     = PEND_W + CODE_W;
    localparam int TOTAL_W   = 5;

    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = FPTR_W + 1;

    localparam logic [OP_W-1:0] OP_ENCODE = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } entry_t;

endpackage

FILE: src/hcbp_ram.sv
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-clock RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/huffman_code_bit_packer.sv
// Huffman code bit packer. A load request writes one symbol's code into a
// 256-entry table RAM; an encode request reads that entry and appends its code,
// MSB first, to a bit accumulator; a flush request pads the partial byte with
// zeros and emits it. One request is accepted per cycle unless the packing
// stage is held by a nearly full output queue. The table read is registered
// when a request is accepted; the packing stage uses the entry once the queue
// has room for two bytes and registers its result bytes into the queue. The
// output port moves one byte per cycle while m_ready is high. The table reads
// as all zero-length codes right after reset, with no clearing pass.
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Code table lookup and MSB-first byte packing with a four-entry output queue.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [hcbp_pkg::OP_W-1:0]     s_operation,
    input  logic [hcbp_pkg::SYM_W-1:0]    s_symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]   s_code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]    s_code_length,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]   m_out_byte,
    output logic                          m_last
);

    import hcbp_pkg::*;

    logic                  accept;
    logic                  sym_ok;
    logic [LEN_W-1:0]      ld_len;
    logic [CODE_W-1:0]     ld_mask;
    entry_t                ld_entry;
    entry_t                rd_entry;
    logic [ADDR_W-1:0]     sym_addr;

    logic [SYMBOL_COUNT-1:0] tvalid_reg;
    logic                  st1_valid_reg;
    logic [OP_W-1:0]       st1_op_reg;
    logic                  st1_hit_reg;
    logic                  st1_go;
    logic                  st1_fire;

    logic [PEND_W-1:0]     pend_bits_reg, pend_bits_next;
    logic [CNT_W-1:0]      pend_cnt_reg, pend_cnt_next;

    logic [LEN_W-1:0]      eff_len;
    logic [CODE_W-1:0]     eff_code;
    logic [ACC_W-1:0]      acc;
    logic [TOTAL_W-1:0]    total;
    logic [ACC_W-1:0]      sh0, sh1;
    logic [BYTE_W-1:0]     rem_mask;
    logic [BYTE_W-1:0]     flush_byte;

    logic [1:0]            push_n;
    logic [BYTE_W-1:0]     push_byte0, push_byte1;
    logic                  push_last0;
    logic                  pop;

    logic [BYTE_W-1:0]     fbyte_reg [FIFO_DEPTH];
    logic                  flast_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg, wr_ptr1;
    logic [FCNT_W-1:0]     fcnt_reg;

    // Request side
    assign st1_go   = (fcnt_reg <= FCNT_W'(FIFO_DEPTH - 2));
    assign st1_fire = st1_valid_reg && st1_go;
    assign s_ready  = !st1_valid_reg || st1_go;
    assign accept   = s_valid && s_ready;
    assign sym_ok   = ({1'b0, s_symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign sym_addr = s_symbol[ADDR_W-1:0];

    assign ld_len   = (s_code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : s_code_length;
    assign ld_mask  = CODE_W'(({(CODE_W + 1){1'b0}} | 1'b1) << ld_len) - CODE_W'(1);
    always_comb begin
        ld_entry.code = s_code_bits & ((ld_len >= LEN_W'(CODE_W)) ? {CODE_W{1'b1}} : ld_mask);
        ld_entry.len  = ld_len;
    end

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .aclk  (aclk),
        .we    (accept && s_operation == OP_LOAD && sym_ok),
        .waddr (sym_addr),
        .wdata (ld_entry),
        .re    (accept && s_operation == OP_ENCODE),
        .raddr (sym_addr),
        .rdata (rd_entry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg    <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            if (accept && s_operation == OP_LOAD && sym_ok) begin
                tvalid_reg[sym_addr] <= 1'b1;
            end
            if (accept) begin
                st1_valid_reg <= 1'b1;
            end else if (st1_go) begin
                st1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_op_reg  <= s_operation;
            st1_hit_reg <= sym_ok && tvalid_reg[sym_addr];
        end
    end

    // Packing stage
    assign eff_len  = st1_hit_reg ? rd_entry.len : '0;
    assign eff_code = st1_hit_reg ? rd_entry.code : '0;
    assign acc      = (ACC_W'(pend_bits_reg) << eff_len) | ACC_W'(eff_code);
    assign total    = TOTAL_W'(pend_cnt_reg) + TOTAL_W'(eff_len);
    assign sh0      = acc >> (total - TOTAL_W'(8));
    assign sh1      = acc >> (total - TOTAL_W'(16));
    assign rem_mask = (BYTE_W'(1) << total[CNT_W-1:0]) - BYTE_W'(1);
    assign flush_byte = BYTE_W'(pend_bits_reg) << (4'd8 - {1'b0, pend_cnt_reg});

    always_comb begin
        push_n         = 2'd0;
        push_byte0     = sh0[BYTE_W-1:0];
        push_byte1     = sh1[BYTE_W-1:0];
        push_last0     = 1'b1;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (st1_fire) begin
            case (st1_op_reg)
                OP_ENCODE: begin
                    if (total >= TOTAL_W'(16)) begin
                        push_n     = 2'd2;
                        push_last0 = 1'b0;
                    end else if (total >= TOTAL_W'(8)) begin
                        push_n = 2'd1;
                    end
                    pend_cnt_next  = total[CNT_W-1:0];
                    pend_bits_next = acc[PEND_W-1:0] & rem_mask[PEND_W-1:0];
                end
                OP_FLUSH: begin
                    if (pend_cnt_reg != '0) begin
                        push_n     = 2'd1;
                        push_byte0 = flush_byte;
                    end
                    pend_cnt_next  = '0;
                    pend_bits_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end else begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    // Output queue
    assign pop        = m_valid && m_ready;
    assign wr_ptr1    = wr_ptr_reg + FPTR_W'(1);
    assign m_valid    = (fcnt_reg != '0);
    assign m_out_byte = fbyte_reg[rd_ptr_reg];
    assign m_last     = flast_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            fbyte_reg[wr_ptr_reg] <= push_byte0;
            flast_reg[wr_ptr_reg] <= push_last0;
        end
        if (push_n == 2'd2) begin
            fbyte_reg[wr_ptr1] <= push_byte1;
            flast_reg[wr_ptr1] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fcnt_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FPTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + FPTR_W'(pop);
            fcnt_reg   <= fcnt_reg + FCNT_W'(push_n) - FCNT_W'(pop);
        end
    end

`ifndef ASSERT_OFF
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= FCNT_W'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_fire && st1_op_reg == OP_LOAD) |-> push_n == 2'd0)
        else $error("load request produced output");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_fire && st1_op_reg == OP_FLUSH) |=> pend_cnt_reg == '0)
        else $error("flush left pending bits");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && fcnt_reg > FCNT_W'(FIFO_DEPTH - 2)) |-> !s_ready)
        else $error("request accepted while packing stage blocked");
`endif

endmodule
